// ===== src/salru_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and fixed field widths for the LRU cache tag store.
// ----------------------------------------------------------------------------
package salru_pkg;

    // fixed port field widths
    localparam int ADDR_IN_W  = 32;
    localparam int SET_OUT_W  = 6;
    localparam int WAY_OUT_W  = 2;
    localparam int TAG_OUT_W  = 20;

    // back end sequencer, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_back_state;

    // one result beat
    typedef struct packed {
        logic                 hit;
        logic [SET_OUT_W-1:0] set_index;
        logic [WAY_OUT_W-1:0] way;
        logic                 evicted;
        logic [TAG_OUT_W-1:0] victim_tag;
    } t_result;

endpackage
`default_nettype wire

// ===== src/salru_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_front
// Takes access beats, splits the address into set and tag, and holds them
// in a two-entry queue for the lookup engine.
// ----------------------------------------------------------------------------
module salru_front #(
    parameter int SETS       = 64,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 32,
    parameter int IDX_W      = 6,
    parameter int TAG_W      = 20
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [salru_pkg::ADDR_IN_W-1:0]  i_address,
    output logic                                  o_busy,
    output logic                                  o_q_valid,
    input  wire logic                             i_q_pop,
    output logic [IDX_W-1:0]                      o_q_set,
    output logic [TAG_W-1:0]                      o_q_tag
);

    localparam int AW       = salru_pkg::ADDR_IN_W;
    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int IDX_BITS = $clog2(SETS);
    localparam int SHIFT    = OFF_BITS + IDX_BITS;
    localparam logic [AW-1:0] ADDR_MASK =
        (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(SETS - 1);

    logic [AW-1:0]    masked;
    logic [AW-1:0]    off_shift;
    logic [AW-1:0]    tag_shift;
    logic [IDX_W-1:0] set_val;
    logic [TAG_W-1:0] tag_val;
    logic             push;

    logic [IDX_W-1:0] r_set [2];
    logic [TAG_W-1:0] r_tag [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;

    // address split
    always_comb begin
        masked    = i_address & ADDR_MASK;
        off_shift = masked >> OFF_BITS;
        tag_shift = masked >> SHIFT;
        set_val   = off_shift[IDX_W-1:0] & IDX_MASK;
        tag_val   = tag_shift[TAG_W-1:0];
    end

    // queue control
    assign o_busy    = (r_count == 2'd2) || !i_rst_n;
    assign push      = i_start && !o_busy;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_set   = r_set[r_rd_ptr];
    assign o_q_tag   = r_tag[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_q_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage, no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_set[r_wr_ptr] <= set_val;
            r_tag[r_wr_ptr] <= tag_val;
        end
    end

endmodule
`default_nettype wire

// ===== src/salru_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_back
// Lookup engine: reads one set row, compares all ways, picks hit, free or
// LRU victim way, writes the updated row and issues the result beat.
// ----------------------------------------------------------------------------
module salru_back #(
    parameter int SETS  = 64,
    parameter int WAYS  = 4,
    parameter int IDX_W = 6,
    parameter int TAG_W = 20,
    parameter int WAY_W = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    output logic                   o_q_pop,
    input  wire logic [IDX_W-1:0]  i_q_set,
    input  wire logic [TAG_W-1:0]  i_q_tag,
    output logic                   o_res_valid,
    output salru_pkg::t_result     o_res
);

    localparam int ENT_W = TAG_W + WAY_W;
    localparam int ROW_W = WAYS * ENT_W;
    localparam logic [WAY_W-1:0] MAX_RANK = WAY_W'(WAYS - 1);
    localparam int SO_W  = salru_pkg::SET_OUT_W;
    localparam int WO_W  = salru_pkg::WAY_OUT_W;
    localparam int TO_W  = salru_pkg::TAG_OUT_W;

    salru_pkg::t_back_state r_state, n_state;

    // set row memory: per way {rank, tag}
    logic [ROW_W-1:0] r_mem [SETS];
    logic [ROW_W-1:0] r_rd_data;
    logic [WAYS-1:0]  r_valid [SETS];
    logic [IDX_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;

    logic                 r_res_valid;
    salru_pkg::t_result   r_res;

    logic [TAG_W-1:0] way_tag  [WAYS];
    logic [WAY_W-1:0] way_rank [WAYS];
    logic [WAYS-1:0]  vld;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             any_free;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] lru_way;
    logic [WAY_W-1:0] sel_way;
    logic             was_valid;
    logic [WAY_W-1:0] old_rank;
    logic [ROW_W-1:0] wr_row;
    logic [WAY_W-1:0] nrank;
    logic             evict;
    logic [TAG_W-1:0] vic_tag;
    logic [IDX_W+SO_W-1:0] set_ext;
    logic [WAY_W+WO_W-1:0] way_ext;
    logic [TAG_W+TO_W-1:0] tag_ext;
    logic             eval;

    assign eval    = (r_state == salru_pkg::S_EVAL);
    assign o_q_pop = (r_state == salru_pkg::S_IDLE) && i_q_valid;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            salru_pkg::S_IDLE: begin
                if (i_q_valid) n_state = salru_pkg::S_EVAL;
            end
            salru_pkg::S_EVAL: begin
                n_state = salru_pkg::S_IDLE;
            end
            default: n_state = salru_pkg::S_IDLE;
        endcase
    end

    // way compare, free search and victim choice over the fetched row
    always_comb begin
        vld      = r_valid[r_set];
        hit      = 1'b0;
        hit_way  = '0;
        any_free = 1'b0;
        free_way = '0;
        lru_way  = '0;
        for (int i = 0; i < WAYS; i++) begin
            way_tag[i]  = r_rd_data[i*ENT_W +: TAG_W];
            way_rank[i] = r_rd_data[i*ENT_W + TAG_W +: WAY_W];
        end
        // lowest-numbered way wins each search
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (vld[i] && (way_tag[i] == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (!vld[i]) begin
                any_free = 1'b1;
                free_way = WAY_W'(i);
            end
            // a full set holds a rank permutation: the oldest has MAX_RANK
            if (way_rank[i] == MAX_RANK) lru_way = WAY_W'(i);
        end
        sel_way   = hit ? hit_way : (any_free ? free_way : lru_way);
        was_valid = hit || !any_free;
        evict     = !hit && !any_free;
        old_rank  = way_rank[sel_way];
        vic_tag   = evict ? way_tag[sel_way] : '0;

        // rank update and tag write
        wr_row = r_rd_data;
        for (int i = 0; i < WAYS; i++) begin
            nrank = way_rank[i];
            if (WAY_W'(i) == sel_way) begin
                nrank = '0;
                wr_row[i*ENT_W +: TAG_W] = r_tag;
            end else if (vld[i] && (!was_valid || (way_rank[i] < old_rank))) begin
                if (way_rank[i] != MAX_RANK) nrank = way_rank[i] + 1'b1;
            end
            wr_row[i*ENT_W + TAG_W +: WAY_W] = nrank;
        end

        set_ext = {{SO_W{1'b0}}, r_set};
        way_ext = {{WO_W{1'b0}}, sel_way};
        tag_ext = {{TO_W{1'b0}}, vic_tag};
    end

    // control registers and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= salru_pkg::S_IDLE;
            r_res_valid <= 1'b0;
            for (int s = 0; s < SETS; s++) r_valid[s] <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= eval;
            if (eval) r_valid[r_set][sel_way] <= 1'b1;
        end
    end

    // row memory: registered read, write on evaluation
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rd_data <= r_mem[i_q_set];
            r_set     <= i_q_set;
            r_tag     <= i_q_tag;
        end
        if (eval) r_mem[r_set] <= wr_row;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (eval) begin
            r_res.hit        <= hit;
            r_res.set_index  <= set_ext[SO_W-1:0];
            r_res.way        <= way_ext[WO_W-1:0];
            r_res.evicted    <= evict;
            r_res.victim_tag <= tag_ext[TO_W-1:0];
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire

// ===== src/set_assoc_cache_lru_tag_store_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted access passes through the queue, the registered row read
// and the result register. The engine takes a new access only when done
// with the last one: each does a set-row read, then compare and write back.
// A two-entry queue lets start be taken while the engine works.
// Reset (synchronous, active low) clears all valid bits at once and empties
// the queue; no clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tag_store_top
// Set-associative tag store with per-set LRU ranks: hit way, fill way, or
// eviction with victim tag for each access address.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tag_store_top #(
    parameter int SETS       = 64,
    parameter int WAYS       = 4,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [salru_pkg::ADDR_IN_W-1:0]     i_address,
    output logic                                     o_valid,
    output logic                                     o_hit,
    output logic [salru_pkg::SET_OUT_W-1:0]          o_set_index,
    output logic [salru_pkg::WAY_OUT_W-1:0]          o_way,
    output logic                                     o_evicted,
    output logic [salru_pkg::TAG_OUT_W-1:0]          o_victim_tag
);

    localparam int EFF_A    = (ADDR_BITS < salru_pkg::ADDR_IN_W) ?
                              ADDR_BITS : salru_pkg::ADDR_IN_W;
    localparam int SHIFT    = $clog2(LINE_BYTES) + $clog2(SETS);
    localparam int IDX_W    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W    = (EFF_A > SHIFT) ? (EFF_A - SHIFT) : 1;

    logic               q_valid;
    logic               q_pop;
    logic [IDX_W-1:0]   q_set;
    logic [TAG_W-1:0]   q_tag;
    salru_pkg::t_result res;

    salru_front #(
        .SETS       (SETS),
        .LINE_BYTES (LINE_BYTES),
        .ADDR_BITS  (ADDR_BITS),
        .IDX_W      (IDX_W),
        .TAG_W      (TAG_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_address (i_address),
        .o_busy    (busy),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_set   (q_set),
        .o_q_tag   (q_tag)
    );

    salru_back #(
        .SETS  (SETS),
        .WAYS  (WAYS),
        .IDX_W (IDX_W),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_set     (q_set),
        .i_q_tag     (q_tag),
        .o_res_valid (o_valid),
        .o_res       (res)
    );

    assign o_hit        = res.hit;
    assign o_set_index  = res.set_index;
    assign o_way        = res.way;
    assign o_evicted    = res.evicted;
    assign o_victim_tag = res.victim_tag;

endmodule
`default_nettype wire

// ===== src/salru_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salru_checker
// Port-level checks on the result beats of the tag store.
// ----------------------------------------------------------------------------
module salru_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic                                o_valid,
    input  wire logic                                o_hit,
    input  wire logic                                o_evicted,
    input  wire logic [salru_pkg::TAG_OUT_W-1:0]     o_victim_tag
);

    // result beats are never back to back
    a_beat_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beats on consecutive cycles");

    // an eviction is always a miss
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |-> !o_hit)
        else $error("eviction reported on a hit");

    // victim tag is zero unless a line was evicted
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted) |-> (o_victim_tag == '0))
        else $error("victim tag without eviction");

    // no beat right after reset, and no accept while held in reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat after reset");

    a_reset_busy: assert property (@(posedge i_clk)
        (!i_rst_n && start) |-> busy)
        else $error("start taken during reset");

endmodule

bind set_assoc_cache_lru_tag_store_top salru_checker u_salru_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_hit        (o_hit),
    .o_evicted    (o_evicted),
    .o_victim_tag (o_victim_tag)
);
`default_nettype wire
